>>> rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned MAP_WORDS_DEF  = 128;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [31:0] CFG_RESET  = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_NOP     = 2'd3
  } pba_op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OOM    = 3'd1,
    ST_RANGE  = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_DOUBLE = 3'd4
  } pba_status_e;

  typedef enum logic [1:0] {
    REG_MEMORY_BASE    = 2'd0,
    REG_RESERVED_START = 2'd1,
    REG_RESERVED_END   = 2'd2
  } pba_reg_e;

  typedef struct packed {
    logic start;
    logic clr_wr;
    logic rsv_diff;
    logic rsv_clamp;
    logic rsv_wr;
    logic alc_scan;
    logic scan_rd;
    logic alc_wr;
    logic alc_addr;
    logic fre_chk;
    logic fre_wr;
    logic load_out;
  } pba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic rsv_empty;
    logic rsv_last;
    logic scan_hit;
    logic scan_last;
    logic chk_err;
  } pba_sts_t;

endpackage

>>> rtl/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pba_dp.sv
// ----------------------------------------------------------------------------
// pba_dp
// Allocator datapath: bitmap RAM, full-word summary, range math, results.
// ----------------------------------------------------------------------------
module pba_dp import pba_pkg::*; #(
  parameter int unsigned MAP_WORDS  = MAP_WORDS_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pba_cmd_t    cmd_i,
  output pba_sts_t    sts_o,
  input  logic [31:0] address_i,
  input  logic [31:0] memory_base_i,
  input  logic [31:0] reserved_start_i,
  input  logic [31:0] reserved_end_i,
  output logic [31:0] page_address_o,
  output logic [2:0]  status_o
);

  localparam int unsigned WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PAGE_W = WORD_W + 5;
  localparam int unsigned NGRP   = (MAP_WORDS + 31) / 32;
  localparam int unsigned GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic [32:0]       TOTAL_PAGES = 33'(MAP_WORDS) * 33'd32;
  localparam logic [32:0]       MAX_PAGE    = TOTAL_PAGES - 33'd1;
  localparam logic [31:0]       PAGE_MASK   = (32'd1 << PAGE_SHIFT) - 32'd1;
  localparam logic [WORD_W-1:0] LAST_WORD   = WORD_W'(MAP_WORDS - 1);
  localparam logic [GRP_W-1:0]  LAST_GRP    = GRP_W'(NGRP - 1);
  localparam logic [31:0]       ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0]       ONE         = 32'd1;

  function automatic logic [4:0] lowest_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  logic [31:0]        addr_q;
  logic [31:0]        d_start_q, d_end_q;
  logic [PAGE_W-1:0]  first_q, last_q;
  logic [WORD_W-1:0]  word_q;
  logic [4:0]         bit_q;
  logic [GRP_W-1:0]   grp_q;
  logic [MAP_WORDS-1:0] full_q;
  logic [31:0]        res_addr_q, out_addr_q;
  pba_status_e        res_status_q, out_status_q;

  logic [31:0]        d_start, d_end;
  logic [32:0]        first_pg, last_raw, last_pg;
  logic [4:0]         mask_lo, mask_hi;
  logic [31:0]        rsv_mask;
  logic [NGRP*32-1:0] full_pad;
  logic [31:0]        grp_slice;
  logic [4:0]         scan_bit;
  logic [GRP_W+4:0]   scan_cat;
  logic [WORD_W-1:0]  scan_word;
  logic [31:0]        fre_off;
  logic [32:0]        fre_pg;
  logic               fre_range, fre_misal;
  logic [4:0]         rd_bit;
  logic [63:0]        page_off;
  logic               ram_we;
  logic [WORD_W-1:0]  ram_addr;
  logic [31:0]        ram_wdata, ram_rdata;

  // reserve range
  assign d_start  = reserved_start_i - memory_base_i;
  assign d_end    = reserved_end_i - memory_base_i + PAGE_MASK;
  assign first_pg = {1'b0, d_start_q} >> PAGE_SHIFT;
  assign last_raw = {1'b0, d_end_q} >> PAGE_SHIFT;
  assign last_pg  = (last_raw >= TOTAL_PAGES) ? MAX_PAGE : last_raw;

  assign mask_lo  = (word_q == first_q[PAGE_W-1:5]) ? first_q[4:0] : 5'd0;
  assign mask_hi  = (word_q == last_q[PAGE_W-1:5]) ? last_q[4:0] : 5'd31;
  assign rsv_mask = (ONES << mask_lo) & (ONES >> (5'd31 - mask_hi));

  // free-word search, one group of 32 words a cycle
  always_comb begin
    full_pad = '1;
    full_pad[MAP_WORDS-1:0] = full_q;
  end
  assign grp_slice = full_pad[grp_q*32 +: 32];
  assign scan_bit  = lowest_zero(grp_slice);
  assign scan_cat  = {grp_q, scan_bit};
  assign scan_word = scan_cat[WORD_W-1:0];

  // free checks
  assign fre_off   = addr_q - memory_base_i;
  assign fre_pg    = {1'b0, fre_off} >> PAGE_SHIFT;
  assign fre_range = (addr_q < memory_base_i) || (fre_pg >= TOTAL_PAGES);
  assign fre_misal = (addr_q & PAGE_MASK) != 32'd0;

  assign rd_bit   = lowest_zero(ram_rdata);
  assign page_off = 64'({word_q, bit_q}) << PAGE_SHIFT;

  assign ram_addr = cmd_i.scan_rd ? scan_word : word_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd_i.rsv_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | rsv_mask;
    end else if (cmd_i.alc_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | (ONE << rd_bit);
    end else if (cmd_i.fre_wr) begin
      ram_we    = ram_rdata[bit_q];
      ram_wdata = ram_rdata & ~(ONE << bit_q);
    end
  end

  pba_ram #(
    .WIDTH(32),
    .DEPTH(MAP_WORDS),
    .AW   (WORD_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      grp_q  <= '0;
      full_q <= '0;
    end else begin
      if (cmd_i.clr_wr || cmd_i.rsv_wr) begin
        word_q <= word_q + WORD_W'(1);
      end else if (cmd_i.rsv_clamp) begin
        word_q <= first_pg[PAGE_W-1:5];
      end else if (cmd_i.alc_scan && sts_o.scan_hit) begin
        word_q <= scan_word;
      end else if (cmd_i.fre_chk) begin
        word_q <= fre_pg[PAGE_W-1:5];
      end
      if (cmd_i.start) begin
        grp_q <= '0;
      end else if (cmd_i.alc_scan && !sts_o.scan_hit) begin
        grp_q <= grp_q + GRP_W'(1);
      end
      if (ram_we) begin
        full_q[word_q] <= &ram_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q       <= address_i;
      res_addr_q   <= '0;
      res_status_q <= ST_OK;
    end
    if (cmd_i.rsv_diff) begin
      d_start_q <= d_start;
      d_end_q   <= d_end;
    end
    if (cmd_i.rsv_clamp) begin
      first_q <= first_pg[PAGE_W-1:0];
      last_q  <= last_pg[PAGE_W-1:0];
    end
    if (cmd_i.alc_scan && !sts_o.scan_hit && sts_o.scan_last) begin
      res_status_q <= ST_OOM;
    end
    if (cmd_i.alc_wr) begin
      bit_q <= rd_bit;
    end
    if (cmd_i.alc_addr) begin
      res_addr_q <= memory_base_i + page_off[31:0];
    end
    if (cmd_i.fre_chk) begin
      bit_q <= fre_pg[4:0];
      if (fre_range) begin
        res_status_q <= ST_RANGE;
      end else if (fre_misal) begin
        res_status_q <= ST_ALIGN;
      end
    end
    if (cmd_i.fre_wr && !ram_rdata[bit_q]) begin
      res_status_q <= ST_DOUBLE;
    end
    if (cmd_i.load_out) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_done  = (word_q == LAST_WORD);
    sts_o.rsv_empty = (first_pg > last_pg);
    sts_o.rsv_last  = (word_q == last_q[PAGE_W-1:5]);
    sts_o.scan_hit  = ~&grp_slice;
    sts_o.scan_last = (grp_q == LAST_GRP);
    sts_o.chk_err   = fre_range || fre_misal;
  end

  assign page_address_o = out_addr_q;
  assign status_o       = out_status_q;

endmodule

>>> rtl/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Allocator sequencer: clearing pass, per-operation steps, result handoff.
// ----------------------------------------------------------------------------
module pba_ctrl import pba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pba_cmd_t   cmd_o,
  input  pba_sts_t   sts_i
);

  typedef enum logic [12:0] {
    S_CLEAR     = 13'b0_0000_0000_0001,
    S_IDLE      = 13'b0_0000_0000_0010,
    S_RSV_DIFF  = 13'b0_0000_0000_0100,
    S_RSV_CLAMP = 13'b0_0000_0000_1000,
    S_RSV_RD    = 13'b0_0000_0001_0000,
    S_RSV_WR    = 13'b0_0000_0010_0000,
    S_ALC_SCAN  = 13'b0_0000_0100_0000,
    S_ALC_WR    = 13'b0_0000_1000_0000,
    S_ALC_ADDR  = 13'b0_0001_0000_0000,
    S_FRE_CHK   = 13'b0_0010_0000_0000,
    S_FRE_RD    = 13'b0_0100_0000_0000,
    S_FRE_WR    = 13'b0_1000_0000_0000,
    S_RESP      = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
        if (in_valid_i) begin
          unique case (pba_op_e'(operation_i))
            OP_RESERVE: state_d = S_RSV_DIFF;
            OP_ALLOC:   state_d = S_ALC_SCAN;
            OP_FREE:    state_d = S_FRE_CHK;
            OP_NOP:     state_d = S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_RSV_DIFF: begin
        cmd_o.rsv_diff = 1'b1;
        state_d        = S_RSV_CLAMP;
      end
      S_RSV_CLAMP: begin
        cmd_o.rsv_clamp = 1'b1;
        state_d         = sts_i.rsv_empty ? S_RESP : S_RSV_RD;
      end
      S_RSV_RD: begin
        state_d = S_RSV_WR;
      end
      S_RSV_WR: begin
        cmd_o.rsv_wr = 1'b1;
        state_d      = sts_i.rsv_last ? S_RESP : S_RSV_RD;
      end
      S_ALC_SCAN: begin
        cmd_o.alc_scan = 1'b1;
        cmd_o.scan_rd  = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_ALC_WR;
        end else if (sts_i.scan_last) begin
          state_d = S_RESP;
        end
      end
      S_ALC_WR: begin
        cmd_o.alc_wr = 1'b1;
        state_d      = S_ALC_ADDR;
      end
      S_ALC_ADDR: begin
        cmd_o.alc_addr = 1'b1;
        state_d        = S_RESP;
      end
      S_FRE_CHK: begin
        cmd_o.fre_chk = 1'b1;
        state_d       = sts_i.chk_err ? S_RESP : S_FRE_RD;
      end
      S_FRE_RD: begin
        state_d = S_FRE_WR;
      end
      S_FRE_WR: begin
        cmd_o.fre_wr = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// Physical page allocator over a used-page bitmap held in a single-port RAM.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared by a pass over all its words, during which
// no item is accepted (register writes are). Items are handled one at a time;
// the bitmap RAM's single port and its read-modify-write set the cost: nop
// goes straight to the result, free checks the address, then reads and writes
// its word unless that check fails, allocate scans the full-word summary by
// groups, then reads and writes the word found, and reserve reads and writes
// each bitmap word its range touches. A finished result waits in an output
// register, so the next item can be taken while it is not yet consumed.
module page_bitmap_allocator_top import pba_pkg::*; #(
  parameter int unsigned MAP_WORDS  = MAP_WORDS_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [31:0]           address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           page_address_o,
  output logic [2:0]            status_o
);

  logic [31:0] memory_base_q, reserved_start_q, reserved_end_q;
  logic        cfg_wr;
  pba_reg_e    cfg_idx;
  pba_cmd_t    cmd;
  pba_sts_t    sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pba_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_base_q    <= CFG_RESET;
      reserved_start_q <= CFG_RESET;
      reserved_end_q   <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MEMORY_BASE:    memory_base_q    <= pwdata;
        REG_RESERVED_START: reserved_start_q <= pwdata;
        REG_RESERVED_END:   reserved_end_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MEMORY_BASE:    prdata = memory_base_q;
      REG_RESERVED_START: prdata = reserved_start_q;
      REG_RESERVED_END:   prdata = reserved_end_q;
      default:            prdata = '0;
    endcase
  end

  pba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pba_dp #(
    .MAP_WORDS (MAP_WORDS),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .address_i       (address_i),
    .memory_base_i   (memory_base_q),
    .reserved_start_i(reserved_start_q),
    .reserved_end_i  (reserved_end_q),
    .page_address_o  (page_address_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while an item is in work");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (page_address_o == 32'd0))
    else $error("nonzero page address with error status");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register loaded over an untaken beat");
`endif

endmodule
